FILE: rtl/core/ascon_pkg.sv
// ----------------------------------------------------------------------------
// ascon_pkg
// shared types, constants and the round function of the ascon engine
// ----------------------------------------------------------------------------
package ascon_pkg;

    localparam logic [63:0] ASCON_IV = 64'h80400c0600000000;
    localparam logic [7:0]  RC_P12   = 8'hf0;
    localparam logic [7:0]  RC_P6    = 8'h96;
    localparam logic [7:0]  RC_STEP  = 8'h0f;
    localparam logic [7:0]  RC_LAST  = 8'h4b;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_AD    = 2'd1;
    localparam logic [1:0] FUNC_TEXT  = 2'd2;
    localparam logic [1:0] FUNC_FINAL = 2'd3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_AD   = 2'd1;
    localparam logic [1:0] PH_TEXT = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_DECRYPT  = 2'd2;

    typedef logic [63:0] word_t;
    typedef word_t [4:0] state_t;

    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,
        OP_INIT  = 3'd1,
        OP_ABS   = 3'd2,
        OP_TEXT  = 3'd3,
        OP_FKEY  = 3'd4,
        OP_TKEY  = 3'd5,
        OP_ROUND = 3'd6,
        OP_DSEP  = 3'd7
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [7:0] rc;
        logic       dom_sep;
        logic       last;
        logic [3:0] cnt;
        logic       dec;
    } dp_cmd_t;

    function automatic word_t rotr(input word_t x, input int r);
        rotr = (x >> r) | (x << (64 - r));
    endfunction

    function automatic word_t lead_mask(input logic [3:0] n);
        word_t m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                m[63 - 8 * i -: 8] = 8'hff;
            end
        end
        lead_mask = m;
    endfunction

    function automatic word_t pad_bits(input logic [3:0] n);
        word_t p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) == n) begin
                p[63 - 8 * i -: 8] = PAD_BYTE;
            end
        end
        pad_bits = p;
    endfunction

    function automatic state_t ascon_round(input state_t si, input logic [7:0] c);
        state_t s;
        word_t  t0, t1, t2, t3, t4;
        s = si;
        s[2] = s[2] ^ {56'd0, c};
        s[0] = s[0] ^ s[4];
        s[4] = s[4] ^ s[3];
        s[2] = s[2] ^ s[1];
        t0 = ~s[0] & s[1];
        t1 = ~s[1] & s[2];
        t2 = ~s[2] & s[3];
        t3 = ~s[3] & s[4];
        t4 = ~s[4] & s[0];
        s[0] = s[0] ^ t1;
        s[1] = s[1] ^ t2;
        s[2] = s[2] ^ t3;
        s[3] = s[3] ^ t4;
        s[4] = s[4] ^ t0;
        s[1] = s[1] ^ s[0];
        s[0] = s[0] ^ s[4];
        s[3] = s[3] ^ s[2];
        s[2] = ~s[2];
        s[0] = s[0] ^ rotr(s[0], 19) ^ rotr(s[0], 28);
        s[1] = s[1] ^ rotr(s[1], 61) ^ rotr(s[1], 39);
        s[2] = s[2] ^ rotr(s[2], 1) ^ rotr(s[2], 6);
        s[3] = s[3] ^ rotr(s[3], 10) ^ rotr(s[3], 17);
        s[4] = s[4] ^ rotr(s[4], 7) ^ rotr(s[4], 41);
        ascon_round = s;
    endfunction

endpackage

FILE: rtl/core/ascon128_aead_engine.sv
// ----------------------------------------------------------------------------
// ascon128_aead_engine
// ascon-128 authenticated encryption and decryption engine
// ----------------------------------------------------------------------------
// One word is taken at a time, and only while the output register is empty or
// being read in the same cycle. A start word runs twelve rounds, an associated
// data word or a non-final text word runs six rounds, a final text word or an
// out-of-order word runs none, and finalize runs twelve rounds. The rate is
// set by the single shared round unit, one round per cycle. Text and tag
// results sit in one output register; while a result waits unread, no new
// word is taken. Decrypt mode is sampled per word; the key is read when used.
module ascon128_aead_engine
    import ascon_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // word_high, word_low, byte_count, pad
    input  logic         s_tlast,  // last_block
    input  logic [1:0]   s_tuser,  // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,  // out_high, out_low, out_bytes, pad
    output logic [2:0]   m_tuser,  // out_kind, tag_match, order_error
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    word_t        key_high_reg, key_low_reg;
    logic         dec_reg;
    dp_cmd_t      cmd;
    word_t        text_out, tag_high, tag_low;
    logic [134:0] pay;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            dec_reg      <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_DECRYPT:  dec_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    ascon_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .func        (s_tuser),
        .byte_count  (s_tdata[131:128]),
        .last_block  (s_tlast),
        .word_high   (s_tdata[63:0]),
        .word_low    (s_tdata[127:64]),
        .decrypt_mode(dec_reg),
        .cmd         (cmd),
        .text_out    (text_out),
        .tag_high    (tag_high),
        .tag_low     (tag_low),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_payload   (pay)
    );

    ascon_datapath u_dp (
        .aclk      (aclk),
        .cmd       (cmd),
        .word_high (s_tdata[63:0]),
        .word_low  (s_tdata[127:64]),
        .key_high  (key_high_reg),
        .key_low   (key_low_reg),
        .text_out  (text_out),
        .tag_high  (tag_high),
        .tag_low   (tag_low)
    );

    assign m_tdata = {4'd0, pay[132:129], pay[128:65], pay[64:1]};
    assign m_tuser = {pay[134], pay[133], pay[0]};

endmodule

FILE: rtl/core/ascon_datapath.sv
// ----------------------------------------------------------------------------
// ascon_datapath
// permutation state, one round per cycle, block absorb and text result
// ----------------------------------------------------------------------------
module ascon_datapath
    import ascon_pkg::*;
(
    input  logic        aclk,
    input  dp_cmd_t     cmd,
    input  word_t       word_high,
    input  word_t       word_low,
    input  word_t       key_high,
    input  word_t       key_low,
    output word_t       text_out,
    output word_t       tag_high,
    output word_t       tag_low
);

    state_t st_reg, st_next;
    word_t  mask, d;

    assign mask     = lead_mask(cmd.cnt);
    assign d        = word_high & mask;
    // tag words with the final key already applied
    assign tag_high = st_reg[3] ^ key_high;
    assign tag_low  = st_reg[4] ^ key_low;

    always_comb begin
        state_t s;
        s = st_reg;
        text_out = '0;
        unique case (cmd.op)
            OP_INIT: begin
                s[0] = ASCON_IV;
                s[1] = key_high;
                s[2] = key_low;
                s[3] = word_high;
                s[4] = word_low;
            end
            OP_ABS: begin
                if (cmd.last) begin
                    s[0] = s[0] ^ d ^ pad_bits(cmd.cnt);
                end else begin
                    s[0] = s[0] ^ word_high;
                end
            end
            OP_TEXT: begin
                if (cmd.dom_sep) begin
                    s[4] = s[4] ^ 64'd1;
                end
                if (cmd.last) begin
                    if (cmd.dec) begin
                        text_out = (s[0] ^ d) & mask;
                        s[0] = (s[0] & ~mask) | d;
                    end else begin
                        s[0] = s[0] ^ d;
                        text_out = s[0] & mask;
                    end
                    s[0] = s[0] ^ pad_bits(cmd.cnt);
                end else begin
                    if (cmd.dec) begin
                        text_out = s[0] ^ word_high;
                        s[0] = word_high;
                    end else begin
                        s[0] = s[0] ^ word_high;
                        text_out = s[0];
                    end
                end
            end
            OP_FKEY: begin
                s[1] = s[1] ^ key_high;
                s[2] = s[2] ^ key_low;
            end
            OP_TKEY: begin
                s[3] = s[3] ^ key_high;
                s[4] = s[4] ^ key_low ^ {63'd0, cmd.dom_sep};
            end
            OP_DSEP: s[4] = s[4] ^ 64'd1;
            OP_ROUND: s = ascon_round(s, cmd.rc);
            default: ;
        endcase
        st_next = s;
    end

    always_ff @(posedge aclk) begin
        st_reg <= st_next;
    end

endmodule

FILE: rtl/core/ascon_ctrl.sv
// ----------------------------------------------------------------------------
// ascon_ctrl
// phase tracking, round sequencing and output register
// ----------------------------------------------------------------------------
module ascon_ctrl
    import ascon_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   func,
    input  logic [3:0]   byte_count,
    input  logic         last_block,
    input  word_t        word_high,
    input  word_t        word_low,
    input  logic         decrypt_mode,
    output dp_cmd_t      cmd,
    input  word_t        text_out,
    input  word_t        tag_high,
    input  word_t        tag_low,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [134:0] m_payload
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_TKEY  = 5'b00100,
        ST_FINAL = 5'b01000,
        ST_CHECK = 5'b10000
    } st_t;

    st_t          state_reg, state_next;
    logic [1:0]   phase_reg, phase_next;
    logic [7:0]   rc_reg, rc_next;
    logic         post_reg, post_next;
    logic         init_reg, init_next;
    logic         dec_reg, dec_next;
    logic         vld_reg, vld_next;
    logic [134:0] pay_reg, pay_next;
    word_t        rh_reg, rl_reg;
    logic         acc, last, outfree;

    assign outfree  = !vld_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && outfree;
    assign acc      = s_tvalid && s_tready;
    assign last     = last_block && (byte_count < 4'd8);
    assign m_tvalid = vld_reg;
    assign m_payload = pay_reg;

    // payload: kind, high, low, bytes, match, error
    function automatic logic [134:0] pack(input logic k, input word_t h, input word_t l,
                                          input logic [3:0] b, input logic t, input logic e);
        pack = {e, t, b, l, h, k};
    endfunction

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        rc_next    = rc_reg;
        post_next  = post_reg;
        init_next  = init_reg;
        dec_next   = dec_reg;
        vld_next   = vld_reg && !m_tready;
        pay_next   = pay_reg;
        cmd        = '{op: OP_HOLD, rc: rc_reg, dom_sep: 1'b0, last: last,
                       cnt: byte_count, dec: decrypt_mode};
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    dec_next = decrypt_mode;
                    unique case (func)
                        FUNC_START: begin
                            cmd.op = OP_INIT;
                            rc_next = RC_P12;
                            post_next = 1'b0;
                            init_next = 1'b1;
                            phase_next = PH_AD;
                            state_next = ST_ROUND;
                        end
                        FUNC_AD: begin
                            if (phase_reg != PH_AD) begin
                                vld_next = 1'b1;
                                pay_next = pack(1'b0, '0, '0, 4'd0, 1'b0, 1'b1);
                            end else begin
                                cmd.op = OP_ABS;
                                rc_next = RC_P6;
                                post_next = last;
                                init_next = 1'b0;
                                if (last) phase_next = PH_TEXT;
                                state_next = ST_ROUND;
                            end
                        end
                        FUNC_TEXT: begin
                            if (phase_reg != PH_AD && phase_reg != PH_TEXT) begin
                                vld_next = 1'b1;
                                pay_next = pack(1'b0, '0, '0, 4'd0, 1'b0, 1'b1);
                            end else begin
                                cmd.op = OP_TEXT;
                                cmd.dom_sep = (phase_reg == PH_AD);
                                vld_next = 1'b1;
                                if (last) begin
                                    pay_next = pack(1'b0, text_out, '0, byte_count,
                                                    1'b0, 1'b0);
                                    phase_next = PH_DONE;
                                end else begin
                                    pay_next = pack(1'b0, text_out, '0, 4'd8, 1'b0, 1'b0);
                                    phase_next = PH_TEXT;
                                    rc_next = RC_P6;
                                    post_next = 1'b0;
                                    init_next = 1'b0;
                                    state_next = ST_ROUND;
                                end
                            end
                        end
                        FUNC_FINAL: begin
                            if (phase_reg != PH_DONE) begin
                                vld_next = 1'b1;
                                pay_next = pack(1'b1, '0, '0, 4'd0, 1'b0, 1'b1);
                            end else begin
                                cmd.op = OP_FKEY;
                                rc_next = RC_P12;
                                phase_next = PH_IDLE;
                                state_next = ST_FINAL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FINAL: begin
                cmd.op = OP_ROUND;
                rc_next = rc_reg - RC_STEP;
                if (rc_reg == RC_LAST) state_next = ST_CHECK;
            end
            ST_ROUND: begin
                cmd.op = OP_ROUND;
                rc_next = rc_reg - RC_STEP;
                if (rc_reg == RC_LAST) state_next = ST_TKEY;
            end
            ST_TKEY: begin
                // key after init, domain separation after last ad block
                if (init_reg) begin
                    cmd.op = OP_TKEY;
                end else if (post_reg) begin
                    cmd.op = OP_DSEP;
                end
                state_next = ST_IDLE;
            end
            ST_CHECK: begin
                cmd.op = OP_TKEY;
                state_next = ST_IDLE;
                vld_next = 1'b1;
                if (dec_reg) begin
                    pay_next = pack(1'b1, '0, '0, 4'd0,
                                    (tag_high == rh_reg) && (tag_low == rl_reg), 1'b0);
                end else begin
                    pay_next = pack(1'b1, tag_high, tag_low, 4'd8, 1'b0, 1'b0);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            rh_reg <= word_high;
            rl_reg <= word_low;
        end
        pay_reg  <= pay_next;
        rc_reg   <= rc_next;
        dec_reg  <= dec_next;
        post_reg <= post_next;
        init_reg <= init_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            vld_reg   <= vld_next;
        end
    end

endmodule

FILE: rtl/core/ascon_checker.sv
// ----------------------------------------------------------------------------
// ascon_checker
// port-level checks on the engine
// ----------------------------------------------------------------------------
module ascon_checker
    import ascon_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic [2:0]   m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata == '0 && !m_tuser[1])
        else $error("order error with payload");

    a_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[131:128] <= 4'd8)
        else $error("byte count out of range");

    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("word taken while a result waits");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid after reset");

endmodule

bind ascon128_aead_engine ascon_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the ascon-128 aead engine: random message sequences
// in both modes, out-of-order words and padding cases, checked word by word
// against an in-bench model of the cipher
// ----------------------------------------------------------------------------
module testbench;
    import ascon_pkg::*;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [3:0]  cnt;
        logic        last;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [3:0]  nbytes;
        logic        match;
        logic        oerr;
    } out_word_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         s_tlast = 0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [135:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_we = 0;
    logic [1:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    ascon128_aead_engine dut (.*);

    always #5 aclk = ~aclk;

    // model state
    logic [63:0] key_hi = '0, key_lo = '0;
    logic        dec_mode = 0;
    logic [63:0] sw [5];
    logic [1:0]  ph = PH_IDLE;

    in_word_t  pending_words [$];
    out_word_t expected_words [$];
    int  errors = 0;
    int  n_text = 0, n_tags = 0, n_oerr = 0;
    bit  no_idle = 0;
    int  hold_cycles = 0;
    int  rx_count = 0;

    function automatic logic [63:0] rot(logic [63:0] x, int r);
        return (x >> r) | (x << (64 - r));
    endfunction

    task automatic run_rounds(logic [7:0] rc0);
        logic [63:0] t0, t1, t2, t3, t4;
        int c;
        for (c = rc0; c >= 8'h4b; c -= 8'h0f) begin
            sw[2] ^= 64'(c);
            sw[0] ^= sw[4]; sw[4] ^= sw[3]; sw[2] ^= sw[1];
            t0 = ~sw[0] & sw[1]; t1 = ~sw[1] & sw[2]; t2 = ~sw[2] & sw[3];
            t3 = ~sw[3] & sw[4]; t4 = ~sw[4] & sw[0];
            sw[0] ^= t1; sw[1] ^= t2; sw[2] ^= t3; sw[3] ^= t4; sw[4] ^= t0;
            sw[1] ^= sw[0]; sw[0] ^= sw[4]; sw[3] ^= sw[2]; sw[2] = ~sw[2];
            sw[0] ^= rot(sw[0], 19) ^ rot(sw[0], 28);
            sw[1] ^= rot(sw[1], 61) ^ rot(sw[1], 39);
            sw[2] ^= rot(sw[2], 1) ^ rot(sw[2], 6);
            sw[3] ^= rot(sw[3], 10) ^ rot(sw[3], 17);
            sw[4] ^= rot(sw[4], 7) ^ rot(sw[4], 41);
        end
    endtask

    function automatic logic [63:0] lead_bytes(logic [3:0] n);
        return (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
    endfunction

    function automatic logic [63:0] pad_of(logic [3:0] n);
        return 64'h80 << (56 - 8 * n);
    endfunction

    task automatic predict_cipher(in_word_t w);
        out_word_t r;
        logic lst;
        logic [63:0] m, d;
        r = '0;
        lst = w.last && w.cnt < 8;
        case (w.func)
            FUNC_START: begin
                sw[0] = ASCON_IV; sw[1] = key_hi; sw[2] = key_lo;
                sw[3] = w.hi; sw[4] = w.lo;
                run_rounds(RC_P12);
                sw[3] ^= key_hi; sw[4] ^= key_lo;
                ph = PH_AD;
                return;
            end
            FUNC_AD: begin
                if (ph != PH_AD) begin
                    r.oerr = 1;
                end else begin
                    if (lst) begin
                        sw[0] ^= (w.hi & lead_bytes(w.cnt)) ^ pad_of(w.cnt);
                        run_rounds(RC_P6);
                        sw[4] ^= 64'd1;
                        ph = PH_TEXT;
                    end else begin
                        sw[0] ^= w.hi;
                        run_rounds(RC_P6);
                    end
                    return;
                end
            end
            FUNC_TEXT: begin
                if (ph != PH_AD && ph != PH_TEXT) begin
                    r.oerr = 1;
                end else begin
                    if (ph == PH_AD) begin
                        sw[4] ^= 64'd1;
                        ph = PH_TEXT;
                    end
                    if (lst) begin
                        m = lead_bytes(w.cnt);
                        d = w.hi & m;
                        if (dec_mode) begin
                            r.hi = (sw[0] ^ d) & m;
                            sw[0] = (sw[0] & ~m) | d;
                        end else begin
                            sw[0] ^= d;
                            r.hi = sw[0] & m;
                        end
                        sw[0] ^= pad_of(w.cnt);
                        r.nbytes = w.cnt;
                        ph = PH_DONE;
                    end else begin
                        if (dec_mode) begin
                            r.hi = sw[0] ^ w.hi;
                            sw[0] = w.hi;
                        end else begin
                            sw[0] ^= w.hi;
                            r.hi = sw[0];
                        end
                        run_rounds(RC_P6);
                        r.nbytes = 4'd8;
                    end
                end
            end
            FUNC_FINAL: begin
                r.kind = 1;
                if (ph != PH_DONE) begin
                    r.oerr = 1;
                end else begin
                    sw[1] ^= key_hi; sw[2] ^= key_lo;
                    run_rounds(RC_P12);
                    sw[3] ^= key_hi; sw[4] ^= key_lo;
                    if (dec_mode) begin
                        r.match = (sw[3] == w.hi) && (sw[4] == w.lo);
                    end else begin
                        r.hi = sw[3]; r.lo = sw[4]; r.nbytes = 4'd8;
                    end
                    ph = PH_IDLE;
                end
            end
        endcase
        expected_words.push_back(r);
    endtask

    // driver
    in_word_t cur;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (s_tvalid) begin
                    predict_cipher(cur);
                end
                if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 26)) begin
                    cur = pending_words.pop_front();
                    s_tvalid <= 1;
                    s_tdata <= {4'd0, cur.cnt, cur.lo, cur.hi};
                    s_tlast <= cur.last;
                    s_tuser <= cur.func;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // monitor
    out_word_t got, exp_w;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.hi = m_tdata[63:0];
                got.lo = m_tdata[127:64];
                got.nbytes = m_tdata[131:128];
                got.kind = m_tuser[0];
                got.match = m_tuser[1];
                got.oerr = m_tuser[2];
                rx_count++;
                if (expected_words.size() == 0) begin
                    $error("unexpected word: hi %h", got.hi);
                    errors++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.oerr) n_oerr++;
                    else if (exp_w.kind) n_tags++;
                    else n_text++;
                    if (got.kind !== exp_w.kind) begin
                        $error("out_kind exp %h got %h", exp_w.kind, got.kind); errors++;
                    end
                    if (got.hi !== exp_w.hi) begin
                        $error("out_high exp %h got %h", exp_w.hi, got.hi); errors++;
                    end
                    if (got.lo !== exp_w.lo) begin
                        $error("out_low exp %h got %h", exp_w.lo, got.lo); errors++;
                    end
                    if (got.nbytes !== exp_w.nbytes) begin
                        $error("out_bytes exp %h got %h", exp_w.nbytes, got.nbytes);
                        errors++;
                    end
                    if (got.match !== exp_w.match) begin
                        $error("tag_match exp %h got %h", exp_w.match, got.match); errors++;
                    end
                    if (got.oerr !== exp_w.oerr) begin
                        $error("order_error exp %h got %h", exp_w.oerr, got.oerr); errors++;
                    end
                end
            end
        end
    end

    // receiver ready, with long holds counted here
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 0;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= 26);
            end
        end
    end

    function automatic in_word_t mk(logic [1:0] f, logic [63:0] h, logic [63:0] l,
                                    logic [3:0] c, logic lst);
        in_word_t w;
        w.func = f; w.hi = h; w.lo = l; w.cnt = c; w.last = lst;
        return w;
    endfunction

    function automatic logic [63:0] r64();
        return {$urandom, $urandom};
    endfunction

    // one message with random content; a final-length middle text word can leave later text words out of order
    task automatic push_message(int n_ad, int n_txt);
        int i;
        pending_words.push_back(mk(FUNC_START, r64(), r64(), 4'($urandom), 1'($urandom)));
        for (i = 0; i < n_ad; i++)
            pending_words.push_back(mk(FUNC_AD, r64(), r64(), 4'($urandom_range(15)), 0));
        if (n_ad > 0 || $urandom_range(1))
            pending_words.push_back(mk(FUNC_AD, r64(), r64(), 4'($urandom_range(7)), 1));
        for (i = 0; i < n_txt; i++)
            pending_words.push_back(mk(FUNC_TEXT, r64(), r64(), 4'($urandom_range(15)),
                                       $urandom_range(3) == 0));
        pending_words.push_back(mk(FUNC_TEXT, r64(), r64(), 4'($urandom_range(7)), 1));
        pending_words.push_back(mk(FUNC_FINAL, r64(), r64(), 4'($urandom), 1'($urandom)));
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_tvalid || expected_words.size() > 0)
            @(negedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] v);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 0;
        case (idx)
            REG_KEY_HIGH: key_hi = v;
            REG_KEY_LOW:  key_lo = v;
            REG_DECRYPT:  dec_mode = v[0];
        endcase
    endtask

    // encrypt a message, then replay its ciphertext and tag in decrypt mode
    task automatic round_trip();
        in_word_t msg [$];
        in_word_t w;
        out_word_t res [$];
        int k;
        write_reg(REG_DECRYPT, 0);
        push_message($urandom_range(2), $urandom_range(3));
        msg = pending_words;
        wait_drained();
        // recover outputs by rerunning the model offline
        write_reg(REG_DECRYPT, 0);
        pending_words.delete();
        for (k = 0; k < msg.size(); k++) begin
            predict_cipher(msg[k]);
        end
        res = expected_words;
        expected_words.delete();
        write_reg(REG_DECRYPT, 1);
        k = 0;
        foreach (msg[i]) begin
            w = msg[i];
            if (w.func == FUNC_TEXT) begin
                w.hi = res[k].hi | (w.hi & ~lead_bytes(res[k].nbytes));
                k++;
            end else if (w.func == FUNC_FINAL) begin
                w.hi = res[k].hi; w.lo = res[k].lo; k++;
            end
            pending_words.push_back(w);
        end
        wait_drained();
    endtask

    initial begin
        int i, j;
        for (i = 0; i < 5; i++) sw[i] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: out-of-order after reset, all-zero and all-one fields
        write_reg(REG_KEY_HIGH, '0);
        write_reg(REG_KEY_LOW, '0);
        pending_words.push_back(mk(FUNC_AD, '1, '1, 4'd15, 1));
        pending_words.push_back(mk(FUNC_TEXT, '1, '1, 4'd3, 1));
        pending_words.push_back(mk(FUNC_FINAL, '0, '0, 4'd0, 0));
        pending_words.push_back(mk(FUNC_START, '0, '0, 4'd0, 0));
        pending_words.push_back(mk(FUNC_TEXT, '1, '1, 4'd0, 1));
        pending_words.push_back(mk(FUNC_TEXT, '1, '0, 4'd0, 1));
        pending_words.push_back(mk(FUNC_AD, '1, '0, 4'd8, 0));
        pending_words.push_back(mk(FUNC_FINAL, '1, '1, 4'd15, 1));
        pending_words.push_back(mk(FUNC_START, '1, '1, 4'd15, 1));
        pending_words.push_back(mk(FUNC_AD, '1, '1, 4'd8, 1));
        pending_words.push_back(mk(FUNC_AD, '1, '1, 4'd0, 1));
        pending_words.push_back(mk(FUNC_TEXT, '1, '1, 4'd15, 1));
        pending_words.push_back(mk(FUNC_TEXT, '1, '1, 4'd7, 1));
        pending_words.push_back(mk(FUNC_FINAL, '1, '1, 4'd8, 0));
        wait_drained();
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_DECRYPT, 1);
        push_message(1, 2);
        wait_drained();
        round_trip();

        // receiver stalls long while the sender keeps offering
        hold_cycles = 300;
        push_message(3, 6);
        wait_drained();

        for (j = 0; j < 24; j++) begin
            write_reg(REG_KEY_HIGH, r64());
            write_reg(REG_KEY_LOW, r64());
            write_reg(REG_DECRYPT, $urandom_range(1));
            no_idle = (j >= 10 && j < 13);
            for (i = 0; i < 3; i++) begin
                if ($urandom_range(9) == 0)
                    pending_words.push_back(mk(2'($urandom), r64(), r64(),
                                               4'($urandom), 1'($urandom)));
                else
                    push_message($urandom_range(2), $urandom_range(3));
            end
            wait_drained();
            if (j % 6 == 0) round_trip();
        end
        no_idle = 0;
        wait_drained();
        $display("covered %0d result words: %0d text words, %0d finalizations, %0d order errors",
                 rx_count, n_text, n_tags, n_oerr);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
